>>> hdl/ass_dtf_pkg.sv
// Package for the subtitle dialogue text filter: character codes, register
// indexes and the types shared by the step logic, the result queue and the top level.
// No dependencies.
package ass_dtf_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned TailDepth  = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;

  localparam logic [CfgIdxW-1:0] CfgHeaderMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFieldsToSkip = 2'd1;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChN      = 8'h4E;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  localparam logic [3:0] FieldsToSkipReset = 4'd8;

  // Per-line parsing state.
  typedef struct packed {
    logic [3:0] sep;    // commas passed in the header
    logic       colon;  // first colon passed
    logic       brace;  // inside an override block
    logic       bs;     // backslash waiting for its next text byte
    logic [1:0] tcnt;   // held-back text bytes
  } line_state_t;

  typedef logic [TailDepth-1:0][7:0] tail_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       text_end;
  } res_t;

  typedef res_t [MaxResults-1:0] res_vec_t;

endpackage

>>> hdl/ass_dtf_step.sv
// Combinational per-byte update of the dialogue text filter: header skip, brace
// and escape handling, hold-back tail and end-of-line trim. Uses ass_dtf_pkg.
module ass_dtf_step (
  input  logic                      mode_i,
  input  logic [3:0]                fts_i,
  input  ass_dtf_pkg::line_state_t  state_i,
  input  ass_dtf_pkg::tail_t        tail_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  output ass_dtf_pkg::line_state_t  state_o,
  output ass_dtf_pkg::tail_t        tail_o,
  output logic [2:0]                res_cnt_o,
  output ass_dtf_pkg::res_vec_t     res_o
);

  ass_dtf_pkg::line_state_t st;
  logic [1:0][7:0] push;
  logic [1:0]      np;
  logic            hdr_colon;
  logic            hdr_field;
  logic [4:0][7:0] tail_x;
  logic [4:0][7:0] seq;
  logic [2:0]      tcnt3;
  logic [2:0]      rel;
  logic [2:0]      len;
  logic [1:0]      e;
  logic [1:0]      m;
  logic [1:0]      n;
  logic [2:0]      rc;
  ass_dtf_pkg::tail_t nt;
  logic            marker;

  always_comb begin
    st        = state_i;
    push      = '0;
    np        = '0;
    hdr_colon = !mode_i && !state_i.colon;
    hdr_field = !hdr_colon && (state_i.sep < fts_i);

    if (hdr_colon) begin
      if (byte_i == ass_dtf_pkg::ChColon) st.colon = 1'b1;
    end else if (hdr_field) begin
      if (byte_i == ass_dtf_pkg::ChComma) st.sep = state_i.sep + 4'd1;
    end else if (state_i.brace) begin
      if (byte_i == ass_dtf_pkg::ChRBrace) st.brace = 1'b0;
    end else if (byte_i == ass_dtf_pkg::ChLBrace) begin
      st.brace = 1'b1;
    end else begin
      if (state_i.bs) begin
        st.bs   = 1'b0;
        push[0] = (byte_i == ass_dtf_pkg::ChN) ? ass_dtf_pkg::ChLf : ass_dtf_pkg::ChBslash;
        np      = 2'd1;
      end
      if (!(state_i.bs && byte_i == ass_dtf_pkg::ChN)) begin
        if (byte_i == ass_dtf_pkg::ChBslash) begin
          st.bs = 1'b1;
        end else begin
          push[np[0]] = byte_i;
          np          = np + 2'd1;
        end
      end
    end

    // A backslash still pending at line end is plain text.
    if (last_i && st.bs) begin
      push[np[0]] = ass_dtf_pkg::ChBslash;
      np          = np + 2'd1;
      st.bs       = 1'b0;
    end

    // Held-back bytes followed by this byte's new text, oldest first.
    tcnt3  = {1'b0, state_i.tcnt};
    tail_x = {16'h0000, tail_i};
    for (int i = 0; i < ass_dtf_pkg::MaxResults; i++) begin
      rel = 3'(i) - tcnt3;
      if (3'(i) < tcnt3) begin
        seq[i] = tail_x[i];
      end else if (rel == 3'd0) begin
        seq[i] = push[0];
      end else begin
        seq[i] = push[1];
      end
    end

    len = tcnt3 + {1'b0, np};
    e   = (len > 3'd3) ? 2'(len - 3'd3) : 2'd0;
    m   = (len > 3'd3) ? 2'd3 : len[1:0];
    for (int j = 0; j < ass_dtf_pkg::TailDepth; j++) begin
      nt[j] = seq[3'(j) + {1'b0, e}];
    end

    // Trailing CR LF trimmed first, then a trailing LF.
    case (m)
      2'd0: n = 2'd0;
      2'd1: n = (nt[0] == ass_dtf_pkg::ChLf) ? 2'd0 : 2'd1;
      2'd2: begin
        if (nt[0] == ass_dtf_pkg::ChCr && nt[1] == ass_dtf_pkg::ChLf) n = 2'd0;
        else if (nt[1] == ass_dtf_pkg::ChLf) n = 2'd1;
        else n = 2'd2;
      end
      default: begin
        if (nt[1] == ass_dtf_pkg::ChCr && nt[2] == ass_dtf_pkg::ChLf) begin
          n = (nt[0] == ass_dtf_pkg::ChLf) ? 2'd0 : 2'd1;
        end else if (nt[2] == ass_dtf_pkg::ChLf) begin
          n = 2'd2;
        end else begin
          n = 2'd3;
        end
      end
    endcase

    if (!last_i) rc = {1'b0, e};
    else if (n == 2'd0) rc = {1'b0, e} + 3'd1;
    else rc = {1'b0, e} + {1'b0, n};

    for (int i = 0; i < ass_dtf_pkg::MaxResults; i++) begin
      marker              = last_i && (n == 2'd0) && (3'(i) == {1'b0, e});
      res_o[i].out_byte   = marker ? 8'h00 : seq[i];
      res_o[i].byte_valid = !marker;
      res_o[i].text_end   = last_i && (3'(i) == rc - 3'd1);
    end

    st.tcnt = m;
    if (last_i) st = '0;
  end

  assign state_o   = st;
  assign tail_o    = nt;
  assign res_cnt_o = rc;

endmodule

>>> hdl/ass_dtf_resq.sv
// Result queue of the dialogue text filter: loads all results of one byte at
// once and hands them out one transfer at a time. Uses ass_dtf_pkg.
module ass_dtf_resq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [2:0]             load_cnt_i,
  input  ass_dtf_pkg::res_vec_t  load_vec_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output ass_dtf_pkg::res_t      head_o,
  output logic                   can_load_o
);

  ass_dtf_pkg::res_vec_t ent_q, ent_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign can_load_o  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);
  assign head_o      = ent_q[0];

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = load_vec_i;
      cnt_d = load_cnt_i;
    end else if (pop) begin
      for (int i = 0; i < ass_dtf_pkg::MaxResults - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(ass_dtf_pkg::MaxResults))
    else $error("result queue count out of range");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !load_i |=> cnt_q == $past(cnt_q) - 3'd1)
    else $error("result queue did not shrink on transfer");
`endif

endmodule

>>> hdl/ass_dialogue_text_filter_core.sv
// Dialogue text filter: the first result of a byte is offered in the cycle after its transfer.
// One byte per cycle while each byte yields at most one result and the receiver does not stall;
// a byte with more results (up to two inside a line, five at line end) admits the next byte as
// its last result leaves the result queue, which hands out one result per cycle unless stalled.
// Reset (rst_ni, asynchronous, active low) clears the line state and result queue and sets
// header_mode to 0 and fields_to_skip to 8; held-back text bytes are not reset.
module ass_dialogue_text_filter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ass_dtf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ass_dtf_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input byte channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         in_byte_i,
  input  logic                               line_end_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               text_end_o
);

  // Configuration registers. Writes are always taken; an unknown index is ignored.
  logic       mode_q, mode_d;
  logic [3:0] fts_q, fts_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    fts_d  = fts_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ass_dtf_pkg::CfgHeaderMode:   mode_d = cfg_data_i[0];
        ass_dtf_pkg::CfgFieldsToSkip: fts_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      fts_q  <= ass_dtf_pkg::FieldsToSkipReset;
    end else begin
      mode_q <= mode_d;
      fts_q  <= fts_d;
    end
  end

  // Line state and the three held-back text bytes. The hold-back lets the
  // trailing CR LF / LF trim happen once the end of the line is seen.
  ass_dtf_pkg::line_state_t line_q, line_d;
  ass_dtf_pkg::tail_t       tail_q, tail_d;
  logic                     in_xfer;
  logic                     can_load;
  logic [2:0]               res_cnt;
  ass_dtf_pkg::res_vec_t    res_vec;
  ass_dtf_pkg::res_t        head;

  // A byte is taken whenever the result queue is empty or its last entry
  // leaves in this very cycle, so single-result bytes stream at full rate.
  assign in_stall_o = !can_load;
  assign in_xfer    = in_valid_i && can_load;

  ass_dtf_step u_step (
    .mode_i    (mode_q),
    .fts_i     (fts_q),
    .state_i   (line_q),
    .tail_i    (tail_q),
    .byte_i    (in_byte_i),
    .last_i    (line_end_i),
    .state_o   (line_d),
    .tail_o    (tail_d),
    .res_cnt_o (res_cnt),
    .res_o     (res_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (in_xfer) begin
      line_q <= line_d;
    end
  end

  // Held-back bytes are only read below the fill count, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tail_q <= tail_d;
    end
  end

  // The queue parts the input side from the result side: it keeps the
  // results of one byte and delivers them one per cycle unless stalled.
  ass_dtf_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer),
    .load_cnt_i  (res_cnt),
    .load_vec_i  (res_vec),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .can_load_o  (can_load)
  );

  assign out_byte_o   = head.out_byte;
  assign byte_valid_o = head.byte_valid;
  assign text_end_o   = head.text_end;

`ifndef SYNTHESIS
  a_line_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && line_end_i |=> out_valid_o)
    else $error("line end produced no result");

  a_line_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && line_end_i |=> line_q == '0)
    else $error("line state not cleared after line end");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> text_end_o && out_byte_o == 8'h00)
    else $error("malformed bare end marker");
`endif

endmodule

>>> verif/ass_dtf_text_model_pkg.sv
// Predictor and result checker for the dialogue text filter testbench.
// Depends on ass_dtf_pkg for character codes, register indexes and the result type.
package ass_dtf_text_model_pkg;

  class dialogue_text_checker;
    logic                  hdr_mode;
    logic [3:0]            skip_fields;
    logic [3:0]            commas_seen;
    logic                  colon_seen;
    logic                  in_override;
    logic                  esc_wait;
    logic [7:0]            held [ass_dtf_pkg::TailDepth];
    int unsigned           held_n;
    ass_dtf_pkg::res_t     text_q [$];
    int unsigned           errors;

    function new();
      hdr_mode    = 1'b0;
      skip_fields = ass_dtf_pkg::FieldsToSkipReset;
      errors      = 0;
      clear_line();
    endfunction

    function void clear_line();
      commas_seen = '0;
      colon_seen  = 1'b0;
      in_override = 1'b0;
      esc_wait    = 1'b0;
      held_n      = 0;
    endfunction

    function void write_reg(input logic [ass_dtf_pkg::CfgIdxW-1:0] idx,
                            input logic [ass_dtf_pkg::CfgDataW-1:0] val);
      case (idx)
        ass_dtf_pkg::CfgHeaderMode:   hdr_mode    = val[0];
        ass_dtf_pkg::CfgFieldsToSkip: skip_fields = val;
        default: ;
      endcase
    endfunction

    function void push_text(input logic [7:0] b, input logic v, input logic e);
      ass_dtf_pkg::res_t r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.text_end   = e;
      text_q.push_back(r);
    endfunction

    // Three bytes are held back; a fourth pushes the oldest out as a result.
    function void hold_byte(input logic [7:0] b);
      if (held_n == ass_dtf_pkg::TailDepth) begin
        push_text(held[0], 1'b1, 1'b0);
        held[0] = held[1];
        held[1] = held[2];
        held[2] = b;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    endfunction

    function void filter_text(input logic [7:0] b);
      if (in_override) begin
        if (b == ass_dtf_pkg::ChRBrace) in_override = 1'b0;
      end else if (b == ass_dtf_pkg::ChLBrace) begin
        in_override = 1'b1;
      end else if (esc_wait && b == ass_dtf_pkg::ChN) begin
        esc_wait = 1'b0;
        hold_byte(ass_dtf_pkg::ChLf);
      end else begin
        if (esc_wait) hold_byte(ass_dtf_pkg::ChBslash);
        esc_wait = (b == ass_dtf_pkg::ChBslash);
        if (b != ass_dtf_pkg::ChBslash) hold_byte(b);
      end
    endfunction

    // Updates the prediction for one accepted input byte.
    function void note_byte(input logic [7:0] b, input logic last);
      int unsigned n;
      if (!hdr_mode && !colon_seen) begin
        if (b == ass_dtf_pkg::ChColon) colon_seen = 1'b1;
      end else if (commas_seen < skip_fields) begin
        if (b == ass_dtf_pkg::ChComma) commas_seen = commas_seen + 4'd1;
      end else begin
        filter_text(b);
      end
      if (last) begin
        if (esc_wait) begin
          esc_wait = 1'b0;
          hold_byte(ass_dtf_pkg::ChBslash);
        end
        n = held_n;
        if (n >= 2 && held[n-2] == ass_dtf_pkg::ChCr && held[n-1] == ass_dtf_pkg::ChLf) n -= 2;
        if (n >= 1 && held[n-1] == ass_dtf_pkg::ChLf) n -= 1;
        if (n == 0) begin
          push_text(8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_text(held[i], 1'b1, (i + 1 == n));
        end
        clear_line();
      end
    endfunction

    function void check_text(input logic [7:0] b, input logic v, input logic e);
      ass_dtf_pkg::res_t want;
      if (text_q.size() == 0) begin
        if (errors < 10)
          $display("%0t: result byte %02h valid %0b end %0b arrived with nothing outstanding",
                   $time, b, v, e);
        errors++;
        return;
      end
      want = text_q.pop_front();
      if (b !== want.out_byte || v !== want.byte_valid || e !== want.text_end) begin
        if (errors < 10)
          $display("%0t: result differs: expected byte %02h valid %0b end %0b, %s %02h %s %0b %s %0b",
                   $time, want.out_byte, want.byte_valid, want.text_end,
                   "got byte", b, "valid", v, "end", e);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return text_q.size();
    endfunction
  endclass

endpackage

>>> verif/tb_ass_dialogue_text_filter_core.sv
// Top level of the dialogue text filter testbench: clock, reset, stimulus, receiver and watchdog.
// Depends on ass_dtf_pkg and on ass_dtf_text_model_pkg for the predictor and checker.
module tb_ass_dialogue_text_filter_core;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 45;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned CycleLimit    = 400000;

  // Register settings per random phase, phase 0 in the lowest position. Both header modes
  // and both extremes of the field count are covered.
  localparam logic [NumPhases-1:0]   PhaseMode = 8'b0101_1010;
  localparam logic [NumPhases*4-1:0] PhaseSkip = {4'd3, 4'd7, 4'd1, 4'd2,
                                                  4'd0, 4'd15, 4'd15, 4'd0};

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [ass_dtf_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ass_dtf_pkg::CfgDataW-1:0] cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [7:0]                       in_byte_i;
  logic                             line_end_i;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [7:0]                       out_byte_o;
  logic                             byte_valid_o;
  logic                             text_end_o;

  ass_dtf_text_model_pkg::dialogue_text_checker text_chk;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  bit          hold_req      = 1'b0;
  bit          hold_active   = 1'b0;
  int unsigned cycle_cnt     = 0;

  ass_dialogue_text_filter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .text_end_o   (text_end_o)
  );

  always #4 clk_i = ~clk_i;

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver side. The stall is chosen at the falling edge, so at the rising edge it is
  // stable, and each result transfer is checked against the oldest expectation there.
  always @(negedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      text_chk.check_text(out_byte_o, byte_valid_o, text_end_o);
  end

  // A long hold-off of the receiver, counted here in cycles. The sender keeps offering bytes
  // meanwhile, so the result queue fills and the block must stall its input.
  initial begin : holdoff
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_active = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end
    end
  end

  // Offers one byte and waits for its transfer. The task is entered and left at a falling
  // edge, and valid is left high, so that back-to-back bytes see a single assignment of valid
  // per edge. Whoever does something else next lowers valid first. While idling, the payload
  // wanders at random, since the block must ignore it.
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'($urandom_range(0, 255));
      line_end_i <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    line_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    text_chk.note_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], close && (i == s.len() - 1));
  endtask

  // The sender pauses until every expected result has come out, then lets the pipeline settle,
  // as a byte that yields no result may still be in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (text_chk.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One register write; like send_item it leaves valid high for a following write.
  task automatic write_reg(input logic [ass_dtf_pkg::CfgIdxW-1:0] idx,
                           input logic [ass_dtf_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    text_chk.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Writes both registers and then an index beyond the register list, which must be ignored.
  // The unused upper bits of the header mode write are random as well.
  task automatic configure(input logic mode, input logic [3:0] skip);
    write_reg(ass_dtf_pkg::CfgHeaderMode, {3'($urandom_range(0, 7)), mode});
    write_reg(ass_dtf_pkg::CfgFieldsToSkip, skip);
    write_reg(ass_dtf_pkg::CfgIdxW'($urandom_range(int'(ass_dtf_pkg::CfgFieldsToSkip) + 1,
                                                    (1 << ass_dtf_pkg::CfgIdxW) - 1)),
              ass_dtf_pkg::CfgDataW'($urandom_range(0, (1 << ass_dtf_pkg::CfgDataW) - 1)));
    cfg_valid_i <= 1'b0;
  endtask

  // Text bytes are weighted towards the characters that the filter treats specially.
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 15))
      0:       return ass_dtf_pkg::ChLBrace;
      1:       return ass_dtf_pkg::ChRBrace;
      2:       return ass_dtf_pkg::ChBslash;
      3:       return ass_dtf_pkg::ChN;
      4:       return ass_dtf_pkg::ChCr;
      5:       return ass_dtf_pkg::ChLf;
      6:       return ass_dtf_pkg::ChComma;
      7:       return ass_dtf_pkg::ChColon;
      8, 9, 10, 11: return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_field_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == ass_dtf_pkg::ChComma) ? ass_dtf_pkg::ChN : b;
  endfunction

  // Builds and sends one line and adds the bytes sent to the count. Most lines carry a
  // correct header for the current settings and random text; one in ten is pure noise and one
  // in ten is cut short, which mostly leaves the header unfinished.
  task automatic send_random_line(inout int unsigned counted);
    logic [7:0]  line_q [$];
    int unsigned kind;
    int unsigned keep;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (!text_chk.hdr_mode) begin
        repeat ($urandom_range(0, 4)) line_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
        line_q.push_back(ass_dtf_pkg::ChColon);
      end
      repeat (text_chk.skip_fields) begin
        repeat ($urandom_range(0, 2)) line_q.push_back(pick_field_byte());
        line_q.push_back(ass_dtf_pkg::ChComma);
      end
      repeat ($urandom_range(0, 10)) line_q.push_back(pick_text_byte());
      case ($urandom_range(0, 4))
        1: begin
          line_q.push_back(ass_dtf_pkg::ChCr);
          line_q.push_back(ass_dtf_pkg::ChLf);
        end
        2: line_q.push_back(ass_dtf_pkg::ChLf);
        3: begin
          line_q.push_back(ass_dtf_pkg::ChLf);
          line_q.push_back(ass_dtf_pkg::ChLf);
        end
        4: line_q.push_back(ass_dtf_pkg::ChCr);
        default: ;
      endcase
      if (kind == 8 && line_q.size() > 1) begin
        keep = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > keep) void'(line_q.pop_back());
      end
      if (line_q.size() == 0) line_q.push_back(pick_text_byte());
    end
    foreach (line_q[i]) begin
      send_item(line_q[i], i == line_q.size() - 1);
      counted++;
    end
  endtask

  initial begin : stimulus
    int unsigned counted;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    line_end_i  = 1'b0;
    text_chk    = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines. With no header at all, the text starts at the first byte. The first line
    // holds an escape whose two bytes are split by an override block, a stray closing brace and
    // both byte extremes.
    configure(1'b1, 4'd0);
    send_string("\\{q}N}", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    // A trailing CR LF is trimmed, and a lone line feed leaves only the bare end marker.
    send_string("x\015\n", 1'b1);
    send_string("\n", 1'b1);
    // A backslash at the end of the line comes out as itself.
    send_string("\\", 1'b1);
    // An override block left open at the end of the line is dropped.
    send_string("{a", 1'b1);
    // A backslash before anything but N is plain text; of two final line feeds one is trimmed.
    send_string("\\b\n\n", 1'b1);
    drain();

    // With the colon mode, a line without a colon yields no text.
    configure(1'b0, 4'd1);
    send_string("ab", 1'b1);
    send_string("x:y,z", 1'b1);
    drain();

    // A register write in the middle of a line: lowering the field count below the commas
    // already seen starts the text at once.
    configure(1'b0, 4'd15);
    send_string(":,,", 1'b0);
    drain();
    configure(1'b0, 4'd1);
    send_string("hi", 1'b1);

    // Random phases, each with its own register settings and idling pattern. The phases with neither
    // input idling nor receiver stalls also carry the long receiver hold-off.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      configure(PhaseMode[p], PhaseSkip[p*4 +: 4]);
      case (p % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          hold_req      = 1'b1;
        end
        1: begin
          in_idle_pct   = 80;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 80;
        end
        default: begin
          in_idle_pct   = 26;
          out_stall_pct = 26;
        end
      endcase
      counted = 0;
      while (counted < ItemsPerPhase) send_random_line(counted);
    end

    drain();
    repeat (SettleCycles * 2) @(negedge clk_i);
    if (text_chk.errors == 0 && text_chk.outstanding() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
hdl/ass_dtf_pkg.sv
hdl/ass_dtf_step.sv
hdl/ass_dtf_resq.sv
hdl/ass_dialogue_text_filter_core.sv
verif/ass_dtf_text_model_pkg.sv
verif/tb_ass_dialogue_text_filter_core.sv
